// ===== hw/rtl/grps_pkg.sv =====
// Package for the gyro rate and power sequencer.
// Holds the sequencer state type, command codes, register addresses, power byte fields,
// the low-pass table and the clock-source selection function. No dependencies.
package grps_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV1,
    ST_DIV2,
    ST_FILT,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    OP_RATE  = 2'd0,
    OP_MASK  = 2'd1,
    OP_CLOCK = 2'd2,
    OP_NONE  = 2'd3
  } opcode_e;

  // Device register addresses.
  localparam logic [5:0] ADDR_DIV  = 6'h15;
  localparam logic [5:0] ADDR_FILT = 6'h16;
  localparam logic [5:0] ADDR_PWR  = 6'h3E;

  // Power-management byte fields.
  localparam logic [7:0] FULL_SCALE = 8'h18;
  localparam logic [7:0] STBY_MASK  = 8'h78;
  localparam logic [7:0] SLEEP_BIT  = 8'h40;
  localparam logic [7:0] STBY_X     = 8'h20;
  localparam logic [7:0] STBY_Y     = 8'h10;
  localparam logic [7:0] STBY_Z     = 8'h08;
  localparam logic [7:0] PWR_RESET  = 8'h78;

  // Clock source codes.
  localparam logic [2:0] CLK_INTERNAL = 3'd0;
  localparam logic [2:0] CLK_GX       = 3'd1;
  localparam logic [2:0] CLK_GY       = 3'd2;
  localparam logic [2:0] CLK_GZ       = 3'd3;

  // Rate arithmetic.
  localparam int unsigned DIV_BITS = 14;
  localparam logic [DIV_BITS-1:0] RATE_RESET = 14'd10;
  localparam logic [DIV_BITS-1:0] BASE_HI    = 14'd8192;
  localparam logic [DIV_BITS-1:0] BASE_LO    = 14'd1024;
  localparam logic [DIV_BITS-1:0] LO_LIMIT   = 14'd256;
  localparam logic [DIV_BITS-1:0] DIV_MAX    = 14'd256;
  localparam logic [15:0]         REQ_MAX    = 16'd8192;
  localparam logic [3:0]          DIV_LAST   = 4'd13;
  localparam logic [2:0]          FILT_FIRST = 3'd1;
  localparam logic [2:0]          FILT_LAST  = 3'd6;

  // Low-pass corner table. The first entry is never compared, since the
  // search always compares the entry after the current filter code.
  function automatic logic [8:0] lp_entry(input logic [2:0] idx);
    logic [8:0] val;
    unique case (idx)
      3'd0:    val = 9'd256;
      3'd1:    val = 9'd188;
      3'd2:    val = 9'd98;
      3'd3:    val = 9'd42;
      3'd4:    val = 9'd20;
      3'd5:    val = 9'd10;
      3'd6:    val = 9'd5;
      default: val = 9'd0;
    endcase
    return val;
  endfunction

  typedef struct packed {
    logic       wr;
    logic [2:0] clk;
  } clk_pick_t;

  // Moves the clock source to the first live gyro of the mask (X, Y, Z), or to internal if
  // none, when the current source is a gyro not in the mask, or internal with gyros on.
  function automatic clk_pick_t pick_clock(input logic [2:0] cur, input logic [2:0] mask);
    logic [2:0] gyro_bit;
    logic       is_gyro_or_int;
    clk_pick_t  res;
    res.wr = 1'b0;
    res.clk = cur;
    is_gyro_or_int = 1'b1;
    unique case (cur)
      CLK_INTERNAL: gyro_bit = 3'b000;
      CLK_GX:       gyro_bit = 3'b001;
      CLK_GY:       gyro_bit = 3'b010;
      CLK_GZ:       gyro_bit = 3'b100;
      default: begin
        gyro_bit = 3'b000;
        is_gyro_or_int = 1'b0;
      end
    endcase
    if (is_gyro_or_int && ((mask & gyro_bit) == 3'b000) &&
        !((gyro_bit == 3'b000) && (mask == 3'b000))) begin
      res.wr = 1'b1;
      priority if (mask[0]) begin
        res.clk = CLK_GX;
      end else if (mask[1]) begin
        res.clk = CLK_GY;
      end else if (mask[2]) begin
        res.clk = CLK_GZ;
      end else begin
        res.clk = CLK_INTERNAL;
      end
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/gyro_rate_power_sequencer_core.sv =====
// Gyro rate and power sequencer: one command in, up to three register writes out.
// Clock and enable commands are planned at the accepting edge, then writes go in order.
// A rate command to a new nonzero rate runs two 14-step restoring divisions on
// one shared divider and a 1 to 6 step filter table search before its writes.
// One command at a time; input stalls until the last write is transferred.
// Reset (async, active low): power byte 0x78, enables 0, current rate 10, idle.
// Depends on grps_pkg.
module gyro_rate_power_sequencer_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] opcode_i,
  input  logic [15:0] rate_request_i,
  input  logic [2:0] axis_mask_i,
  input  logic [2:0] clock_choice_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [5:0] reg_addr_o,
  output logic [7:0] reg_data_o,
  output logic [grps_pkg::DIV_BITS-1:0] rate_now_o,
  output logic [2:0] enables_now_o,
  output logic       last_write_o
);
  import grps_pkg::*;

  state_e state_q, state_d;

  logic [7:0]          pwr_q;
  logic [2:0]          en_q;
  logic [DIV_BITS-1:0] rate_q;
  logic [1:0]          cnt_q;
  logic [1:0]          idx_q;
  logic [5:0]          wa_q [3];
  logic [7:0]          wd_q [3];

  // Shared divider and rate datapath.
  logic [DIV_BITS-1:0] rem_q, quo_q, dvs_q;
  logic [3:0]          step_q;
  logic                hi_base_q;
  logic [8:0]          divv_q;
  logic [2:0]          filt_q;

  logic in_xfer, out_xfer;

  // Command plan built at the accepting edge.
  logic [DIV_BITS-1:0] req_c;
  logic [1:0]          p_cnt;
  logic [5:0]          p_addr [3];
  logic [7:0]          p_data [3];
  logic [7:0]          p_pwr;
  logic [2:0]          p_en;
  logic [DIV_BITS-1:0] p_rate;
  logic                p_div;
  logic                do_enables;
  logic [2:0]          new_mask;
  clk_pick_t           pick1, pick2;

  logic [DIV_BITS:0]   div_shift, div_diff;
  logic                div_ge;
  logic [DIV_BITS-1:0] rem_d, quo_d;
  logic [8:0]          div_clamped;
  logic                div_done;
  logic                filt_more;
  logic [8:0]          div_m1;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_xfer = out_valid_o && !out_stall_i;

  always_comb begin
    req_c = (rate_request_i > REQ_MAX) ? BASE_HI : rate_request_i[DIV_BITS-1:0];
    p_cnt = 2'd0;
    for (int i = 0; i < 3; i++) begin
      p_addr[i] = ADDR_PWR;
      p_data[i] = 8'h00;
    end
    p_pwr = pwr_q;
    p_en = en_q;
    p_rate = rate_q;
    p_div = 1'b0;
    do_enables = 1'b0;
    new_mask = axis_mask_i;
    unique case (opcode_e'(opcode_i))
      OP_RATE: begin
        if (req_c != rate_q) begin
          if (req_c == '0) begin
            do_enables = 1'b1;
            new_mask = 3'b000;
            p_rate = '0;
          end else begin
            p_div = 1'b1;
          end
        end
      end
      OP_MASK: do_enables = 1'b1;
      OP_CLOCK: begin
        p_pwr = {pwr_q[7:3], clock_choice_i};
        p_data[0] = p_pwr;
        p_cnt = 2'd1;
      end
      default: ;
    endcase
    pick1 = pick_clock(p_pwr[2:0], en_q & new_mask);
    if (do_enables && (new_mask != en_q)) begin
      // Leave a gyro that is going away before touching the standby bits.
      if (pick1.wr) begin
        p_pwr[2:0] = pick1.clk;
        p_data[p_cnt] = p_pwr;
        p_cnt = p_cnt + 2'd1;
      end
      p_pwr = p_pwr & ~STBY_MASK;
      if (new_mask == 3'b000) p_pwr = p_pwr | SLEEP_BIT;
      if (!new_mask[0]) p_pwr = p_pwr | STBY_X;
      if (!new_mask[1]) p_pwr = p_pwr | STBY_Y;
      if (!new_mask[2]) p_pwr = p_pwr | STBY_Z;
      p_data[p_cnt] = p_pwr;
      p_cnt = p_cnt + 2'd1;
      p_en = new_mask;
    end
    pick2 = pick_clock(p_pwr[2:0], new_mask);
    if (do_enables && (new_mask != en_q) && pick2.wr) begin
      p_pwr[2:0] = pick2.clk;
      p_data[p_cnt] = p_pwr;
      p_cnt = p_cnt + 2'd1;
    end
  end

  // One restoring division step per cycle.
  always_comb begin
    div_shift = {rem_q, quo_q[DIV_BITS-1]};
    div_diff = div_shift - {1'b0, dvs_q};
    div_ge = div_shift >= {1'b0, dvs_q};
    rem_d = div_ge ? div_diff[DIV_BITS-1:0] : div_shift[DIV_BITS-1:0];
    quo_d = {quo_q[DIV_BITS-2:0], div_ge};
    div_done = (step_q == DIV_LAST);
    div_clamped = (quo_d > DIV_MAX) ? DIV_MAX[8:0] : quo_d[8:0];
    // The corner table is decreasing, so the search only ever steps upward.
    filt_more = !hi_base_q && (filt_q < FILT_LAST) &&
                ({4'b0000, lp_entry(filt_q + 3'd1)} >= rate_q[DIV_BITS-1:1]);
    div_m1 = divv_q - 9'd1;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (p_div) begin
            state_d = ST_DIV1;
          end else if (p_cnt != 2'd0) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_DIV1: if (div_done) state_d = ST_DIV2;
      ST_DIV2: if (div_done) state_d = ST_FILT;
      ST_FILT: if (!filt_more) state_d = ST_EMIT;
      ST_EMIT: if (out_xfer && last_write_o) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    out_valid_o = (state_q == ST_EMIT);
  end

  assign reg_addr_o    = wa_q[idx_q];
  assign reg_data_o    = wd_q[idx_q];
  assign rate_now_o    = rate_q;
  assign enables_now_o = en_q;
  assign last_write_o  = (idx_q == (cnt_q - 2'd1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pwr_q <= PWR_RESET;
      en_q <= 3'b000;
      rate_q <= RATE_RESET;
      cnt_q <= 2'd0;
      idx_q <= 2'd0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            pwr_q <= p_pwr;
            en_q <= p_en;
            rate_q <= p_rate;
            cnt_q <= p_cnt;
            idx_q <= 2'd0;
          end
        end
        ST_DIV2: if (div_done) rate_q <= quo_d;
        ST_FILT: begin
          if (!filt_more) begin
            cnt_q <= 2'd2;
            idx_q <= 2'd0;
          end
        end
        ST_EMIT: if (out_xfer && !last_write_o) idx_q <= idx_q + 2'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          for (int i = 0; i < 3; i++) begin
            wa_q[i] <= p_addr[i];
            wd_q[i] <= p_data[i];
          end
          hi_base_q <= (req_c > LO_LIMIT);
          rem_q <= '0;
          quo_q <= (req_c > LO_LIMIT) ? BASE_HI : BASE_LO;
          dvs_q <= req_c;
          step_q <= 4'd0;
        end
      end
      ST_DIV1: begin
        if (div_done) begin
          // Second pass divides the base by the clamped divider.
          divv_q <= div_clamped;
          rem_q <= '0;
          quo_q <= hi_base_q ? BASE_HI : BASE_LO;
          dvs_q <= {5'b00000, div_clamped};
          step_q <= 4'd0;
        end else begin
          rem_q <= rem_d;
          quo_q <= quo_d;
          step_q <= step_q + 4'd1;
        end
      end
      ST_DIV2: begin
        rem_q <= rem_d;
        quo_q <= quo_d;
        step_q <= step_q + 4'd1;
        if (div_done) filt_q <= hi_base_q ? 3'd0 : FILT_FIRST;
      end
      ST_FILT: begin
        if (filt_more) begin
          filt_q <= filt_q + 3'd1;
        end else begin
          wa_q[0] <= ADDR_FILT;
          wd_q[0] <= FULL_SCALE | {5'b00000, filt_q};
          wa_q[1] <= ADDR_DIV;
          wd_q[1] <= div_m1[7:0];
        end
      end
      default: ;
    endcase
  end

endmodule
